@@ sv/fwrl_pkg.sv @@
package fwrl_pkg;

	localparam int TableDepth = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam logic [15:0] CountMax = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_CHECK   = 2'd0,
		OP_FAILURE = 2'd1,
		OP_SUCCESS = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_WINDOW     = 2'd0,
		CFG_MAX_TOTAL  = 2'd1,
		CFG_MAX_CLIENT = 2'd2,
		CFG_MAX_TRACK  = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DECIDE,
		ST_PURGE,
		ST_PURGE_LAST,
		ST_VICTIM,
		ST_WRITE,
		ST_OUT
	} state_t;

	// one stored client record
	typedef struct packed {
		logic [63:0] key;
		logic [15:0] count;
		logic [31:0] first_time;
		logic [31:0] last_time;
	} entry_t;

	// table memory access from the controller
	typedef struct packed {
		logic            rd_en;
		logic [IdxW-1:0] rd_addr;
		logic            wr_en;
		logic [IdxW-1:0] wr_addr;
		entry_t          wr_data;
	} mem_req_t;

	// elapsed seconds since first, zero when time went back
	function automatic logic [31:0] elapsed(input logic [31:0] now, input logic [31:0] first);
		return (now >= first) ? now - first : 32'd0;
	endfunction

	function automatic logic is_stale(input logic [31:0] now, input logic [31:0] first,
		input logic [16:0] win);
		return elapsed(now, first) >= {15'd0, win};
	endfunction

	function automatic logic [16:0] retry(input logic [31:0] now, input logic [31:0] first,
		input logic [16:0] win);
		logic [31:0] e;
		logic [31:0] left;
		e = elapsed(now, first);
		left = (e < {15'd0, win}) ? {15'd0, win} - e : 32'd0;
		return (left == 32'd0) ? 17'd1 : left[16:0];
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] c);
		return (c == CountMax) ? CountMax : c + 16'd1;
	endfunction

endpackage

@@ sv/fwrl_table.sv @@
module fwrl_table (
	input  logic              clk,
	input  fwrl_pkg::mem_req_t req,
	output fwrl_pkg::entry_t  rd_data
);
	import fwrl_pkg::*;

	entry_t mem [TableDepth];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

@@ sv/fwrl_ctrl.sv @@
module fwrl_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              op,
	input  logic [63:0]             client_key,
	input  logic [31:0]             now_seconds,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    blocked,
	output logic [16:0]             retry_after,
	input  logic [16:0]             win,
	input  logic [15:0]             max_total,
	input  logic [15:0]             max_client,
	input  logic [4:0]              max_track,
	output fwrl_pkg::mem_req_t      req,
	input  fwrl_pkg::entry_t        rd_data,
	output fwrl_pkg::state_t        state
);
	import fwrl_pkg::*;

	state_t state_q, state_d;
	op_t op_q;
	logic [63:0] key_q;
	logic [31:0] now_q;
	logic [TableDepth-1:0] valid_q;
	logic [15:0] gcount_q;
	logic [31:0] gfirst_q;
	logic [IdxW-1:0] ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic rd_pend_q;
	logic hit_q;
	logic [IdxW-1:0] slot_q;
	entry_t slot_e_q;
	logic vic_q;
	logic [IdxW-1:0] vic_idx_q;
	logic [31:0] vic_last_q;
	logic [63:0] vic_key_q;
	logic blocked_q;
	logic [16:0] retry_q;
	logic [CntW-1:0] cap;
	logic [CntW-1:0] occ;
	logic gate_ok;
	logic last_ptr;
	logic rd_live;
	logic rd_hit;
	logic rd_stale;
	logic rd_better;
	logic [IdxW-1:0] free_idx;
	logic free_any;
	logic [TableDepth-1:0] valid_d;
	logic g_stale;

	assign state = state_q;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign blocked = blocked_q;
	assign retry_after = retry_q;
	assign last_ptr = (ptr_q == IdxW'(TableDepth - 1));

	// capacity clamp to 1..depth
	always_comb begin
		if (max_track == 5'd0) begin
			cap = CntW'(1);
		end else if ({27'd0, max_track} > TableDepth) begin
			cap = CntW'(TableDepth);
		end else begin
			cap = CntW'(max_track);
		end
	end

	// occupancy and lowest free slot
	always_comb begin
		occ = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TableDepth - 1; i >= 0; i--) begin
			occ = occ + CntW'(valid_q[i]);
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IdxW'(i);
			end
		end
	end

	assign g_stale = is_stale(now_q, gfirst_q, win);
	// global gate decides a check without using the table lookup result
	assign gate_ok = (max_total != 16'd0) && (gcount_q >= max_total) && !g_stale;

	// evaluation of the word that came back from the table
	assign rd_live = valid_q[rd_ptr_q];
	assign rd_hit = rd_live && (rd_data.key == key_q);
	assign rd_stale = is_stale(now_q, rd_data.first_time, win);
	assign rd_better = !vic_q || (rd_data.last_time < vic_last_q) ||
		((rd_data.last_time == vic_last_q) && (rd_data.key < vic_key_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_ptr) begin
					state_d = ST_SCAN_LAST;
				end
			end
			ST_SCAN_LAST: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (op_q == OP_FAILURE && !hit_q && occ >= cap) begin
					state_d = ST_PURGE;
				end else if (op_q == OP_FAILURE) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_PURGE: begin
				if (last_ptr) begin
					state_d = ST_PURGE_LAST;
				end
			end
			ST_PURGE_LAST: state_d = ST_VICTIM;
			ST_VICTIM: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OUT;
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory requests
	always_comb begin
		req = '0;
		req.rd_addr = ptr_q;
		req.wr_addr = hit_q ? slot_q : free_idx;
		req.rd_en = (state_q == ST_SCAN) || (state_q == ST_PURGE);
		req.wr_data = slot_e_q;
		if (state_q == ST_WRITE && (hit_q || free_any)) begin
			req.wr_en = 1'b1;
			if (!hit_q) begin
				req.wr_data.key = key_q;
				req.wr_data.count = 16'd1;
				req.wr_data.first_time = now_q;
			end else if (is_stale(now_q, slot_e_q.first_time, win)) begin
				req.wr_data.count = 16'd1;
				req.wr_data.first_time = now_q;
			end else begin
				req.wr_data.count = bump(slot_e_q.count);
			end
			req.wr_data.last_time = now_q;
		end
	end

	// valid bit updates
	always_comb begin
		valid_d = valid_q;
		case (state_q)
			ST_SCAN_LAST, ST_PURGE_LAST, ST_SCAN, ST_PURGE: ;
			ST_DECIDE: begin
				if (hit_q && op_q == OP_SUCCESS) begin
					valid_d[slot_q] = 1'b0;
				end
				if (hit_q && op_q == OP_CHECK && !gate_ok &&
					is_stale(now_q, slot_e_q.first_time, win)) begin
					valid_d[slot_q] = 1'b0;
				end
			end
			ST_VICTIM: begin
				if (occ >= cap && vic_q) begin
					valid_d[vic_idx_q] = 1'b0;
				end
			end
			ST_WRITE: begin
				if (hit_q || free_any) begin
					valid_d[hit_q ? slot_q : free_idx] = 1'b1;
				end
			end
			default: ;
		endcase
		// purge of expired entries as they come back
		if ((state_q == ST_PURGE || state_q == ST_PURGE_LAST) && rd_pend_q && rd_live &&
			rd_stale) begin
			valid_d[rd_ptr_q] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_CHECK;
			key_q <= '0;
			now_q <= '0;
			valid_q <= '0;
			gcount_q <= '0;
			gfirst_q <= '0;
			ptr_q <= '0;
			rd_ptr_q <= '0;
			rd_pend_q <= 1'b0;
			hit_q <= 1'b0;
			slot_q <= '0;
			slot_e_q <= '0;
			vic_q <= 1'b0;
			vic_idx_q <= '0;
			vic_last_q <= '0;
			vic_key_q <= '0;
			blocked_q <= 1'b0;
			retry_q <= '0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			rd_pend_q <= req.rd_en;
			rd_ptr_q <= ptr_q;
			if (req.rd_en) begin
				ptr_q <= ptr_q + IdxW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					hit_q <= 1'b0;
					vic_q <= 1'b0;
					blocked_q <= 1'b0;
					retry_q <= '0;
					if (in_valid) begin
						op_q <= op_t'(op);
						key_q <= client_key;
						now_q <= now_seconds;
					end
				end
				ST_DECIDE: begin
					ptr_q <= '0;
					if (op_q == OP_CHECK) begin
						if (gate_ok) begin
							blocked_q <= 1'b1;
							retry_q <= retry(now_q, gfirst_q, win);
						end else begin
							if (max_total != 16'd0 && gcount_q >= max_total) begin
								gcount_q <= '0;
								gfirst_q <= '0;
							end
							if (hit_q && !is_stale(now_q, slot_e_q.first_time, win) &&
								slot_e_q.count >= max_client) begin
								blocked_q <= 1'b1;
								retry_q <= retry(now_q, slot_e_q.first_time, win);
							end
						end
					end else if (op_q == OP_FAILURE) begin
						if (gcount_q == 16'd0 || g_stale) begin
							gcount_q <= 16'd1;
							gfirst_q <= now_q;
						end else begin
							gcount_q <= bump(gcount_q);
						end
					end else if (op_q == OP_SUCCESS) begin
						gcount_q <= '0;
						gfirst_q <= '0;
					end
				end
				default: ;
			endcase
			// lookup pass
			if ((state_q == ST_SCAN || state_q == ST_SCAN_LAST) && rd_pend_q && rd_hit) begin
				hit_q <= 1'b1;
				slot_q <= rd_ptr_q;
				slot_e_q <= rd_data;
			end
			// purge pass also tracks the eviction candidate
			if ((state_q == ST_PURGE || state_q == ST_PURGE_LAST) && rd_pend_q && rd_live &&
				!rd_stale && rd_better) begin
				vic_q <= 1'b1;
				vic_idx_q <= rd_ptr_q;
				vic_last_q <= rd_data.last_time;
				vic_key_q <= rd_data.key;
			end
		end
	end

endmodule

@@ sv/failure_window_rate_limiter.sv @@
// failure_window_rate_limiter
// Words enter on in (op, client_key, now_seconds) with valid/ready and one
// result word (blocked, retry_after) leaves on out for every input word.
// Registers are written through cfg (index, data); the user must do so only while
// the block is idle, which the block itself does not enforce: 0 window_seconds,
// 1 max_failures_total, 2 max_failures_per_client, 3 max_tracked_clients.
// The client table lives in a 16-entry synchronous memory read once a cycle during a pass.
// Every word makes a lookup pass over the memory; a failure from a client not in the
// table, when occupancy has reached the capacity, adds a second pass (expiry purge
// plus victim search). A check, success or unused op then goes to the result; a
// failure first writes its table entry. One word is in flight at a time.
// The result waits in the output register until taken; in_ready stays low
// meanwhile. Reset clears all valid bits, the global counter and restores
// register defaults; no clearing pass is needed.
module failure_window_rate_limiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] client_key,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        blocked,
	output logic [16:0] retry_after,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import fwrl_pkg::*;

	logic [16:0] win_q;
	logic [15:0] max_total_q;
	logic [15:0] max_client_q;
	logic [4:0]  max_track_q;
	mem_req_t    req;
	entry_t      rd_data;
	state_t      state;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 17'd900;
			max_total_q <= 16'd0;
			max_client_q <= 16'd5;
			max_track_q <= 5'd16;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WINDOW:     win_q <= cfg_data;
				CFG_MAX_TOTAL:  max_total_q <= cfg_data[15:0];
				CFG_MAX_CLIENT: max_client_q <= cfg_data[15:0];
				CFG_MAX_TRACK:  max_track_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	fwrl_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .op, .client_key, .now_seconds,
		.out_valid, .out_ready, .blocked, .retry_after,
		.win(win_q), .max_total(max_total_q), .max_client(max_client_q),
		.max_track(max_track_q), .req, .rd_data, .state
	);

	fwrl_table u_table (.clk, .req, .rd_data);

	// input and output handshakes never both live
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("in_ready and out_valid together");
	// result held while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(blocked) && $stable(retry_after))
		else $error("result changed under stall");
	// no write to the table outside the write step
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> state == ST_WRITE)
		else $error("stray table write");
	// blocked carries a nonzero retry
	a_retry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blocked |-> retry_after != 17'd0)
		else $error("blocked without retry");

endmodule
